[rtl/core/rational_add_mul_unit_macros.svh]
// assertion macros for the rational add/multiply unit
// no dependencies
`ifndef RATIONAL_ADD_MUL_UNIT_MACROS_SVH
`define RATIONAL_ADD_MUL_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RAM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ramu_pkg.sv]
// package for the rational add/multiply unit: types and constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ramu_pkg;

    localparam int unsigned W = 32;
    localparam int unsigned CW = 6;

    typedef logic [W-1:0] word_t;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1
    } func_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_A,
        ST_NORM_B,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_NORM_R,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

    // datapath operations the controller issues
    typedef struct packed {
        logic load;      // capture request
        logic prep_a;    // sign fix and gcd setup for operand a
        logic prep_b;
        logic mul1;
        logic mul2;
        logic mul3;
        logic prep_r;
        logic gcd_step;
        logic div_start_n;
        logic div_start_d;
        logic div_step;
        logic store;     // latch quotient into the selected operand
        logic [1:0] target; // 0 a, 1 b, 2 result
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic trivial;   // zero numerator, no gcd needed
        logic gcd_done;
        logic div_done;
    } ctrl_stat_t;

    localparam logic [1:0] TGT_A = 2'd0;
    localparam logic [1:0] TGT_B = 2'd1;
    localparam logic [1:0] TGT_R = 2'd2;

endpackage

`default_nettype wire

[rtl/core/ramu_ctrl.sv]
// controller state machine for the rational add/multiply unit
// depends on ramu_pkg and rational_add_mul_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "rational_add_mul_unit_macros.svh"

module ramu_ctrl
    import ramu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic       out_free,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    state_t     state_reg, state_next;
    logic [1:0] tgt_reg, tgt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tgt_reg   <= TGT_A;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_NORM_A;
            ST_NORM_A:
            begin
                tgt_next   = TGT_A;
                state_next = stat.trivial ? ST_NORM_B : ST_GCD;
            end
            ST_NORM_B:
            begin
                tgt_next   = TGT_B;
                state_next = stat.trivial ? ST_MUL1 : ST_GCD;
            end
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_NORM_R;
            ST_NORM_R:
            begin
                tgt_next   = TGT_R;
                state_next = stat.trivial ? ST_DONE : ST_GCD;
            end
            ST_GCD:    if (stat.gcd_done) state_next = ST_DIVN;
            ST_DIVN:   if (stat.div_done) state_next = ST_DIVD;
            ST_DIVD:
            begin
                if (stat.div_done)
                begin
                    case (tgt_reg)
                        TGT_A:   state_next = ST_NORM_B;
                        TGT_B:   state_next = ST_MUL1;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.target = tgt_reg;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:   cmd.load = in_fire;
            ST_NORM_A: begin cmd.prep_a = 1'b1; cmd.target = TGT_A; end
            ST_NORM_B: begin cmd.prep_b = 1'b1; cmd.target = TGT_B; end
            ST_MUL1:   cmd.mul1 = 1'b1;
            ST_MUL2:   cmd.mul2 = 1'b1;
            ST_MUL3:   cmd.mul3 = 1'b1;
            ST_NORM_R: begin cmd.prep_r = 1'b1; cmd.target = TGT_R; end
            ST_GCD:
            begin
                cmd.gcd_step    = !stat.gcd_done;
                cmd.div_start_n = stat.gcd_done;
            end
            ST_DIVN:
            begin
                cmd.div_step    = !stat.div_done;
                cmd.div_start_d = stat.div_done;
                cmd.store       = stat.div_done;
            end
            ST_DIVD:
            begin
                cmd.div_step = !stat.div_done;
                cmd.store    = stat.div_done;
            end
            ST_DONE:   cmd.out_load = out_free;
            default:   cmd = '0;
        endcase
    end

    `RAM_ASSERT_IMP(a_load_idle, cmd.load, state_reg == ST_IDLE, "load outside idle")
    `RAM_ASSERT_NEXT(a_fire_go, in_fire && !busy, state_reg == ST_NORM_A, "request dropped")
    `RAM_ASSERT_IMP(a_store_div, cmd.store, stat.div_done, "store before divide ends")

endmodule

`default_nettype wire

[rtl/core/ramu_dpath.sv]
// datapath: operand registers, multiplier, binary gcd and restoring divider
// depends on ramu_pkg
`timescale 1ns / 1ps
`default_nettype none

module ramu_dpath
    import ramu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       func,
    input  wire logic [31:0] a_num,
    input  wire logic [31:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [31:0] b_den,
    input  wire ctrl_cmd_t  cmd,
    output ctrl_stat_t      stat,
    output logic [31:0]     res_num,
    output logic [31:0]     res_den
);

    logic  func_reg;
    word_t an_reg, ad_reg, bn_reg, bd_reg, rn_reg, rd_reg;
    word_t p1_reg, p2_reg;
    // gcd state
    word_t gx_reg, gy_reg;
    logic [CW-1:0] sh_reg;
    // divider state
    word_t q_reg, dv_reg;
    logic [W:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic  div_busy_reg;
    logic  sgn_reg;
    word_t nn_reg, dd_reg;   // sign fixed pair under reduction
    word_t qn_reg;

    word_t sel_n, sel_d, fn, fd, mn, md;
    logic  zden;

    function automatic word_t mag(input word_t v);
        mag = v[W-1] ? (word_t'(0) - v) : v;
    endfunction

    always_comb
    begin
        case (cmd.target)
            TGT_A:   begin sel_n = an_reg; sel_d = ad_reg; end
            TGT_B:   begin sel_n = bn_reg; sel_d = bd_reg; end
            default: begin sel_n = rn_reg; sel_d = rd_reg; end
        endcase
        zden = (sel_d == '0);
        fn   = sel_n;
        fd   = zden ? word_t'(1) : sel_d;
        if (fd[W-1])
        begin
            fn = word_t'(0) - fn;
            fd = word_t'(0) - fd;
        end
        mn = mag(fn);
        md = mag(fd);
    end

    assign stat.trivial = (sel_n == '0);

    // binary gcd: strip common twos, then subtract
    logic  gx_ev, gy_ev;
    word_t gdiff;
    assign gx_ev = !gx_reg[0];
    assign gy_ev = !gy_reg[0];
    assign gdiff = (gx_reg > gy_reg) ? gx_reg - gy_reg : gy_reg - gx_reg;
    assign stat.gcd_done = (gy_reg == '0) || (gx_reg == gy_reg);

    word_t gcd_val;
    assign gcd_val = gx_reg << sh_reg;

    assign stat.div_done = !div_busy_reg;

    logic [W:0] rem_sh;
    assign rem_sh = {rem_reg[W-1:0], q_reg[W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_busy_reg <= 1'b0;
        else if (cmd.div_start_n || cmd.div_start_d)
            div_busy_reg <= 1'b1;
        else if (cmd.div_step && cnt_reg == CW'(W-1))
            div_busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            an_reg <= a_num; ad_reg <= a_den;
            bn_reg <= b_num; bd_reg <= b_den;
        end
        if (cmd.prep_a || cmd.prep_b || cmd.prep_r)
        begin
            if (stat.trivial)
            begin
                case (cmd.target)
                    TGT_A:   ad_reg <= word_t'(1);
                    TGT_B:   bd_reg <= word_t'(1);
                    default: rd_reg <= word_t'(1);
                endcase
            end
            nn_reg <= fn;
            dd_reg <= fd;
            gx_reg <= mn;
            gy_reg <= md;
            sh_reg <= '0;
        end
        if (cmd.gcd_step)
        begin
            if (gx_ev && gy_ev)
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                sh_reg <= sh_reg + CW'(1);
            end
            else if (gx_ev)
                gx_reg <= gx_reg >> 1;
            else if (gy_ev)
                gy_reg <= gy_reg >> 1;
            else if (gx_reg > gy_reg)
                gx_reg <= gdiff;
            else
                gy_reg <= gdiff;
        end
        if (cmd.div_start_n || cmd.div_start_d)
        begin
            if (cmd.div_start_n)
                dv_reg <= (gy_reg == '0) ? gcd_val : (gx_reg << sh_reg);
            q_reg   <= cmd.div_start_n ? mag(nn_reg) : mag(dd_reg);
            sgn_reg <= cmd.div_start_n ? nn_reg[W-1] : dd_reg[W-1];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, dv_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dv_reg};
                q_reg   <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.store && cmd.div_start_d)
            qn_reg <= sgn_reg ? word_t'(0) - q_reg : q_reg;
        if (cmd.store && !cmd.div_start_d)
        begin
            case (cmd.target)
                TGT_A:   begin an_reg <= qn_reg;
                         ad_reg <= sgn_reg ? word_t'(0) - q_reg : q_reg; end
                TGT_B:   begin bn_reg <= qn_reg;
                         bd_reg <= sgn_reg ? word_t'(0) - q_reg : q_reg; end
                default: begin rn_reg <= qn_reg;
                         rd_reg <= sgn_reg ? word_t'(0) - q_reg : q_reg; end
            endcase
        end
        if (cmd.mul1)
        begin
            p1_reg <= an_reg * bd_reg;
            p2_reg <= bn_reg * ad_reg;
        end
        if (cmd.mul2)
        begin
            rn_reg <= (func_reg == FUNC_MUL[0]) ? an_reg * bn_reg : p1_reg + p2_reg;
        end
        if (cmd.mul3)
            rd_reg <= ad_reg * bd_reg;
        if (cmd.out_load)
        begin
            res_num <= rn_reg;
            res_den <= rd_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rational_add_mul_unit.sv]
// rational add/multiply unit top level; depends on ramu_pkg, ramu_ctrl, ramu_dpath
// sequence: accept, normalize a and b, multiply, normalize the result, load the output register;
// each of up to three non-trivial reductions adds a binary gcd run and two restoring divisions
// throughput: one request at a time; the next is taken once the result is in the output register
// reset: rst_n async low clears the controller and the output valid flag
`timescale 1ns / 1ps
`default_nettype none

module rational_add_mul_unit
    import ramu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [31:0] a_num,
    input  wire logic [31:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [31:0] b_den,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      res_num,
    output logic [31:0]      res_den
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       busy;
    logic       in_fire, out_free;
    logic       out_valid_reg;

    // output register frees as soon as the consumer takes it
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !busy;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    ramu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    ramu_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .func    (func),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .cmd     (cmd),
        .stat    (stat),
        .res_num (res_num),
        .res_den (res_den)
    );

endmodule

`default_nettype wire

[tb/tb_rational_add_mul_unit.sv]
// testbench for the rational add/multiply unit: random and directed fraction requests,
// results checked against a built-in reduced-fraction predictor
// depends on ramu_pkg and rational_add_mul_unit
`timescale 1ns / 1ps

module tb_rational_add_mul_unit;
    import ramu_pkg::*;

    typedef struct packed {
        logic        op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } frac_req_t;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
    } frac_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] res_num;
    logic [31:0] res_den;

    rational_add_mul_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den)
    );

    // pending requests for the driver, expected reduced fractions for the monitor
    frac_req_t pending_reqs[$];
    frac_res_t expected_fracs[$];

    int  errors = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 0;
    localparam int CYCLE_LIMIT = 10000000;

    // acceptance seen at the last rising edge
    logic in_ready_seen = 1'b0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // magnitude of a 32-bit two's complement word, |-2^31| = 2^31
    function automatic logic [31:0] abs_word(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] gcd_word(logic [31:0] x, logic [31:0] y);
        logic [31:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [31:0] scale_down(logic [31:0] v, logic [31:0] g);
        logic [31:0] q;
        if (g == 0)
            g = 32'd1;
        q = abs_word(v) / g;
        return v[31] ? -q : q;
    endfunction

    // canonical form: zero den -> 1, zero num -> 0/1, sign on numerator, gcd removed
    function automatic frac_res_t reduce_frac(logic [31:0] n, logic [31:0] d);
        frac_res_t r;
        logic [31:0] g;
        if (d == 0)
            d = 32'd1;
        if (n == 0)
        begin
            r.num = 32'd0;
            r.den = 32'd1;
            return r;
        end
        if (d[31])
        begin
            n = -n;
            d = -d;
        end
        g = gcd_word(abs_word(n), abs_word(d));
        r.num = scale_down(n, g);
        r.den = scale_down(d, g);
        return r;
    endfunction

    function automatic frac_res_t rational_result(frac_req_t q);
        frac_res_t x;
        frac_res_t y;
        logic [31:0] n;
        x = reduce_frac(q.an, q.ad);
        y = reduce_frac(q.bn, q.bd);
        if (q.op == FUNC_MUL[0])
            n = x.num * y.num;
        else
            n = x.num * y.den + y.num * x.den;
        return reduce_frac(n, x.den * y.den);
    endfunction

    task automatic push_req(logic op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
        frac_req_t q;
        q.op = op;
        q.an = an;
        q.ad = ad;
        q.bn = bn;
        q.bd = bd;
        pending_reqs.push_back(q);
    endtask

    // random operand word: mostly small values so reductions actually happen,
    // sometimes full-width or a corner value
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return {1'($urandom_range(0, 1)), 31'd0};
            3: return $urandom_range(0, 2) - 1;
            4: return 32'h7fff_ffff - $urandom_range(0, 1);
            5: return $urandom_range(0, 65535) << $urandom_range(0, 16);
            6: return -($urandom_range(1, 1000));
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_fracs.size() != 0)
            @(posedge clk);
    endtask

    // driver: offers requests at the falling edge, holds them until accepted
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= 1'b0;
            a_num    <= '0;
            a_den    <= '0;
            b_num    <= '0;
            b_den    <= '0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                frac_req_t q;
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                func  <= q.op;
                a_num <= q.an;
                a_den <= q.ad;
                b_num <= q.bn;
                b_den <= q.bd;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // the predictor runs on the accepted request
    always @(posedge clk)
    begin
        in_ready_seen <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_fracs.push_back(rational_result({func, a_num, a_den, b_num, b_den}));
    end

    // receiver ready, with random stalls or a long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: compares each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fracs.size() == 0)
            begin
                $error("unexpected result res_num=%0d res_den=%0d",
                       $signed(res_num), $signed(res_den));
                errors++;
            end
            else
            begin
                frac_res_t e;
                e = expected_fracs.pop_front();
                if (res_num !== e.num)
                begin
                    $error("res_num expected %0d actual %0d", $signed(e.num), $signed(res_num));
                    errors++;
                end
                if (res_den !== e.den)
                begin
                    $error("res_den expected %0d actual %0d", $signed(e.den), $signed(res_den));
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int hold_cycles;
        int i;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero dens, zero nums, sign flips, -2^31 wraps, extremes, both ops
        push_req(FUNC_ADD[0], 32'd1, 32'd2, 32'd1, 32'd3);
        push_req(FUNC_MUL[0], 32'd2, 32'd4, 32'd3, 32'd9);
        push_req(FUNC_ADD[0], 32'd5, 32'd0, 32'd7, 32'd0);
        push_req(FUNC_MUL[0], 32'd0, 32'd5, 32'd3, 32'd7);
        push_req(FUNC_ADD[0], 32'd0, 32'd0, 32'd0, 32'd0);
        push_req(FUNC_ADD[0], 32'd3, -32'd6, -32'd4, -32'd8);
        push_req(FUNC_MUL[0], 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
        push_req(FUNC_MUL[0], 32'd1, 32'h8000_0000, 32'd1, 32'd1);
        push_req(FUNC_ADD[0], 32'h8000_0000, -32'd1, 32'd0, 32'd1);
        push_req(FUNC_MUL[0], 32'd1, 32'h1_0000, 32'd1, 32'h1_0000);
        push_req(FUNC_MUL[0], 32'd1, 32'h2_0000, 32'd1, 32'h8000);
        push_req(FUNC_ADD[0], 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        push_req(FUNC_MUL[0], 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_req(FUNC_ADD[0], 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_req(FUNC_MUL[0], 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        push_req(FUNC_ADD[0], 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
        push_req(FUNC_ADD[0], 32'd1, 32'd2, -32'd1, 32'd2);
        push_req(FUNC_MUL[0], 32'd6, 32'd35, 32'd14, 32'd15);

        // phase one: sender idles lightly, receiver heavily
        send_idle_pct = 21;
        recv_idle_pct = 62;
        for (i = 0; i < 650; i++)
            push_req($urandom_range(0, 1), rand_word(), rand_word(), rand_word(), rand_word());
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        recv_hold = 1'b1;
        for (i = 0; i < 20; i++)
            push_req($urandom_range(0, 1), rand_word(), rand_word(), rand_word(), rand_word());
        hold_cycles = 0;
        while (hold_cycles < 2000)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        recv_hold = 1'b0;
        wait_drained();

        // phase two: roles swapped
        send_idle_pct = 62;
        recv_idle_pct = 21;
        for (i = 0; i < 640; i++)
            push_req($urandom_range(0, 1), rand_word(), rand_word(), rand_word(), rand_word());
        wait_drained();

        // phase three: no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < 640; i++)
            push_req($urandom_range(0, 1), rand_word(), rand_word(), rand_word(), rand_word());
        wait_drained();

        repeat (300) @(posedge clk);
        if (errors == 0 && expected_fracs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[rational_add_mul_unit.f]
+incdir+rtl/core
rtl/core/ramu_pkg.sv
rtl/core/ramu_ctrl.sv
rtl/core/ramu_dpath.sv
rtl/core/rational_add_mul_unit.sv
tb/tb_rational_add_mul_unit.sv
